@@ src/kced_pkg.sv @@
// Shared types and constants for the key click event detector.
// Used by kced_cfg_regs, kced_phase_logic, kced_state_mem and the top level.
// No dependencies.
package kced_pkg;

  // Default sizing
  localparam int NUM_KEYS_DEF    = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int KEY_W   = 3;
  localparam int CODE_W  = 3;
  localparam int PHASE_W = 3;
  localparam int TICK_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W  = 3;

  // Key phases
  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DEB    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PRESS  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LONG   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_WAIT2  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DEB2   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_PRESS2 = 3'd6;

  // Event codes
  localparam logic [CODE_W-1:0] EV_NONE   = 3'd0;
  localparam logic [CODE_W-1:0] EV_SINGLE = 3'd1;
  localparam logic [CODE_W-1:0] EV_DOUBLE = 3'd2;
  localparam logic [CODE_W-1:0] EV_LONG   = 3'd3;
  localparam logic [CODE_W-1:0] EV_REPEAT = 3'd4;

  // Mode bit positions
  localparam int MODE_LONG_BIT   = 0;
  localparam int MODE_REPEAT_BIT = 1;
  localparam int MODE_DOUBLE_BIT = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WAIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LVL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd5;

  // Register reset values
  localparam logic [TICK_W-1:0] DEBOUNCE_RST    = 16'd20;
  localparam logic [TICK_W-1:0] LONG_PRESS_RST  = 16'd1000;
  localparam logic [TICK_W-1:0] REPEAT_RST      = 16'd100;
  localparam logic [TICK_W-1:0] DOUBLE_WAIT_RST = 16'd300;
  localparam logic              PRESSED_LVL_RST = 1'b0;
  localparam logic [MODE_W-1:0] MODE_RST        = 3'd7;

  typedef struct packed {
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] long_press_ticks;
    logic [TICK_W-1:0] repeat_ticks;
    logic [TICK_W-1:0] double_wait_ticks;
    logic              pressed_level;
    logic [MODE_W-1:0] mode_bits;
  } cfg_t;

endpackage

@@ src/key_click_event_detector_unit.sv @@
// Top level of the key click event detector.
// Depends on kced_pkg, kced_cfg_regs, kced_state_mem and kced_phase_logic.
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+-------------------------------
// in      | input     | in_valid / in_stall  | in_key_index, in_pin_level
// out     | output    | out_valid / out_stall| out_event_key, out_event_code
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Cycles: one beat per clock sustained while out_stall is low. The state memory
//   read is registered with stage 1; the phase update and write-back happen
//   as the beat leaves stage 1, into the registered result. The state memory's
//   single read and write port, with a one-entry bypass for back-to-back beats
//   of the same key, makes that rate possible.
// Reset: rst_n low clears the pipeline and the per-key valid bits and resets the
//   configuration; no clearing pass, the block accepts beats right after reset.
// Stalls: out_stall holds the output register; the pipeline stage in front
//   still takes a beat while it is empty, and in_stall is raised once it is full.
module key_click_event_detector_unit #(
  parameter int NUM_KEYS    = kced_pkg::NUM_KEYS_DEF,
  parameter int COUNT_WIDTH = kced_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input beats
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kced_pkg::KEY_W-1:0]      in_key_index,
  input  logic                            in_pin_level,
  // result beats
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kced_pkg::KEY_W-1:0]      out_event_key,
  output logic [kced_pkg::CODE_W-1:0]     out_event_code,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kced_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kced_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int XW = (AW > kced_pkg::KEY_W) ? AW : kced_pkg::KEY_W;
  localparam int CW = COUNT_WIDTH;
  localparam int PW = kced_pkg::PHASE_W;
  localparam int EW = PW + 2 * CW;

  kced_pkg::cfg_t cfg;

  // Input side
  logic          in_accept;
  logic [XW-1:0] key_ext;
  logic [AW-1:0] in_addr;
  logic          in_hit;
  logic          in_press;

  // Stage 1: waiting on the memory read
  logic                       s1_valid_r, s1_valid_nxt;
  logic [kced_pkg::KEY_W-1:0] s1_key_r;
  logic [AW-1:0]              s1_addr_r;
  logic                       s1_press_r;
  logic                       s1_hit_r;
  logic                       s1_move;

  // Memory and update
  logic [EW-1:0]              rd_entry;
  logic [EW-1:0]              wr_entry;
  logic                       wr_en;
  logic [PW-1:0]              phase_nxt;
  logic [CW-1:0]              tick_nxt;
  logic [CW-1:0]              saved_nxt;
  logic [kced_pkg::CODE_W-1:0] upd_code;

  // Output register
  logic                        out_valid_r, out_valid_nxt;
  logic [kced_pkg::KEY_W-1:0]  out_key_r;
  logic [kced_pkg::CODE_W-1:0] out_code_r;

  kced_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance stage 1 when the output register is empty or being drained.
  assign s1_move   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_move;
  assign in_accept = in_valid && !in_stall;

  assign key_ext  = XW'(in_key_index);
  assign in_addr  = key_ext[AW-1:0];
  assign in_hit   = 32'(in_key_index) < NUM_KEYS;
  assign in_press = (in_pin_level == cfg.pressed_level);

  kced_state_mem #(
    .NUM_KEYS (NUM_KEYS),
    .AW       (AW),
    .EW       (EW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept && in_hit),
    .rd_addr (in_addr),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (wr_entry),
    .rd_data (rd_entry)
  );

  kced_phase_logic #(
    .CW (CW)
  ) u_phase (
    .phase      (rd_entry[EW-1 -: PW]),
    .tick       (rd_entry[2*CW-1 -: CW]),
    .saved      (rd_entry[CW-1:0]),
    .press      (s1_press_r),
    .cfg        (cfg),
    .phase_nxt  (phase_nxt),
    .tick_nxt   (tick_nxt),
    .saved_nxt  (saved_nxt),
    .event_code (upd_code)
  );

  // Write back as the beat leaves stage 1; out-of-range keys touch nothing.
  assign wr_en    = s1_move && s1_hit_r;
  assign wr_entry = {phase_nxt, tick_nxt, saved_nxt};

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: hold unless a new beat moves in.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_key_r   <= in_key_index;
      s1_addr_r  <= in_addr;
      s1_press_r <= in_press;
      s1_hit_r   <= in_hit;
    end
    if (s1_move) begin
      out_key_r  <= s1_key_r;
      out_code_r <= s1_hit_r ? upd_code : kced_pkg::EV_NONE;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_key  = out_key_r;
  assign out_event_code = out_code_r;

  // A beat moving out of stage 1 lands in the output register.
  a_move_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r && (out_key_r == $past(s1_key_r)))
    else $error("stage 1 beat did not reach the output register");

  // Out-of-range keys never write state and report no event.
  a_miss_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && !s1_hit_r) |=> (out_code_r == kced_pkg::EV_NONE))
    else $error("out-of-range key produced an event");

  // Never accept a beat while stage 1 is held.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_move) |-> !in_accept)
    else $error("input accepted over a held stage 1 beat");

  // A held output beat keeps stage 1 from moving.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !s1_move)
    else $error("stage 1 advanced into a stalled output register");

  // Event codes stay in the defined set.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_code_r <= kced_pkg::EV_REPEAT))
    else $error("undefined event code");

endmodule

@@ src/kced_cfg_regs.sv @@
// Configuration register file for the key click event detector.
// Depends on kced_pkg (register indexes, reset values, cfg_t).
module kced_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kced_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kced_pkg::CFG_DATA_W-1:0]   cfg_data,
  output kced_pkg::cfg_t                    cfg
);

  kced_pkg::cfg_t cfg_r;
  kced_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        kced_pkg::REG_DEBOUNCE:    cfg_nxt.debounce_ticks    = cfg_data;
        kced_pkg::REG_LONG_PRESS:  cfg_nxt.long_press_ticks  = cfg_data;
        kced_pkg::REG_REPEAT:      cfg_nxt.repeat_ticks      = cfg_data;
        kced_pkg::REG_DOUBLE_WAIT: cfg_nxt.double_wait_ticks = cfg_data;
        kced_pkg::REG_PRESSED_LVL: cfg_nxt.pressed_level     = cfg_data[0];
        kced_pkg::REG_MODE:        cfg_nxt.mode_bits = cfg_data[kced_pkg::MODE_W-1:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks    <= kced_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ticks  <= kced_pkg::LONG_PRESS_RST;
      cfg_r.repeat_ticks      <= kced_pkg::REPEAT_RST;
      cfg_r.double_wait_ticks <= kced_pkg::DOUBLE_WAIT_RST;
      cfg_r.pressed_level     <= kced_pkg::PRESSED_LVL_RST;
      cfg_r.mode_bits         <= kced_pkg::MODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ src/kced_state_mem.sv @@
// Per-key state memory with valid bits and a one-entry write bypass.
// Entry layout is {phase, tick_count, saved_count}; depends on kced_pkg.
module kced_state_mem #(
  parameter int NUM_KEYS = kced_pkg::NUM_KEYS_DEF,
  parameter int AW       = 3,
  parameter int EW       = 35
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [EW-1:0] wr_data,
  output logic [EW-1:0] rd_data
);

  logic [EW-1:0]       mem [NUM_KEYS];
  logic [EW-1:0]       rd_data_r;
  logic [AW-1:0]       rd_addr_r;
  logic                rd_valid_r;
  logic [NUM_KEYS-1:0] valid_r;
  logic [EW-1:0]       fwd_data_r;
  logic [AW-1:0]       fwd_addr_r;
  logic                fwd_vld_r;
  logic                fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
    if (wr_en) begin
      fwd_data_r <= wr_data;
      fwd_addr_r <= wr_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      fwd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
        fwd_vld_r        <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // Last write always wins: it is at least as new as the array word.
  assign fwd_hit = fwd_vld_r && (fwd_addr_r == rd_addr_r);

  always_comb begin
    if (fwd_hit) begin
      rd_data = fwd_data_r;
    end else if (rd_valid_r) begin
      rd_data = rd_data_r;
    end else begin
      rd_data = '0; // never written: idle, counters zero
    end
  end

endmodule

@@ src/kced_phase_logic.sv @@
// Next-state and event logic of one key for one tick.
// Depends on kced_pkg (phases, event codes, mode bits, cfg_t).
module kced_phase_logic #(
  parameter int CW = kced_pkg::COUNT_WIDTH_DEF
) (
  input  logic [kced_pkg::PHASE_W-1:0] phase,
  input  logic [CW-1:0]                tick,
  input  logic [CW-1:0]                saved,
  input  logic                         press,
  input  kced_pkg::cfg_t               cfg,
  output logic [kced_pkg::PHASE_W-1:0] phase_nxt,
  output logic [CW-1:0]                tick_nxt,
  output logic [CW-1:0]                saved_nxt,
  output logic [kced_pkg::CODE_W-1:0]  event_code
);

  localparam int CMPW = (CW > kced_pkg::TICK_W) ? CW : kced_pkg::TICK_W;

  logic [CMPW-1:0] tick_ext;
  logic [CMPW-1:0] rep_ext;
  logic [CMPW-1:0] max_ext;
  logic            ge_deb;
  logic            ge_long;
  logic            ge_rep;
  logic            ge_dwait;
  logic [CW-1:0]   tick_inc;
  logic [CW:0]     sum_full;
  logic [CW-1:0]   tick_sum;
  logic [CW-1:0]   rep_load;
  logic            mode_long;
  logic            mode_rep;
  logic            mode_dbl;

  assign tick_ext = CMPW'(tick);
  assign rep_ext  = CMPW'(cfg.repeat_ticks);
  assign max_ext  = CMPW'({CW{1'b1}});
  assign ge_deb   = tick_ext >= CMPW'(cfg.debounce_ticks);
  assign ge_long  = tick_ext >= CMPW'(cfg.long_press_ticks);
  assign ge_rep   = tick_ext >= rep_ext;
  assign ge_dwait = tick_ext >= CMPW'(cfg.double_wait_ticks);

  // Saturate at the counter width
  assign tick_inc = (tick == {CW{1'b1}}) ? tick : tick + CW'(1);
  assign sum_full = {1'b0, tick} + {1'b0, saved};
  assign tick_sum = sum_full[CW] ? {CW{1'b1}} : sum_full[CW-1:0];
  assign rep_load = (rep_ext > max_ext) ? {CW{1'b1}} : rep_ext[CW-1:0];

  assign mode_long = cfg.mode_bits[kced_pkg::MODE_LONG_BIT];
  assign mode_rep  = cfg.mode_bits[kced_pkg::MODE_REPEAT_BIT];
  assign mode_dbl  = cfg.mode_bits[kced_pkg::MODE_DOUBLE_BIT];

  always_comb begin
    phase_nxt  = phase;
    tick_nxt   = tick;
    saved_nxt  = saved;
    event_code = kced_pkg::EV_NONE;
    case (phase)
      kced_pkg::PH_DEB: begin
        if (press && ge_deb) begin
          tick_nxt  = '0;
          phase_nxt = kced_pkg::PH_PRESS;
        end else if (press) begin
          tick_nxt = tick_inc;
        end else begin
          tick_nxt  = '0;
          phase_nxt = kced_pkg::PH_IDLE;
        end
      end
      kced_pkg::PH_PRESS: begin
        if (press && ge_long) begin
          tick_nxt  = rep_load;
          phase_nxt = kced_pkg::PH_LONG;
        end else if (press) begin
          tick_nxt = tick_inc;
        end else if (mode_dbl) begin
          tick_nxt  = '0;
          phase_nxt = kced_pkg::PH_WAIT2;
        end else begin
          tick_nxt   = '0;
          phase_nxt  = kced_pkg::PH_IDLE;
          event_code = kced_pkg::EV_SINGLE;
        end
      end
      kced_pkg::PH_LONG: begin
        if (press) begin
          if (mode_rep) begin
            if (ge_rep) begin
              tick_nxt   = '0;
              event_code = kced_pkg::EV_REPEAT;
            end else begin
              tick_nxt = tick_inc;
            end
          end else begin
            tick_nxt = '0;
          end
        end else begin
          tick_nxt   = '0;
          phase_nxt  = kced_pkg::PH_IDLE;
          event_code = mode_long ? kced_pkg::EV_LONG : kced_pkg::EV_SINGLE;
        end
      end
      kced_pkg::PH_WAIT2: begin
        if (!press && ge_dwait) begin
          tick_nxt   = '0;
          phase_nxt  = kced_pkg::PH_IDLE;
          event_code = kced_pkg::EV_SINGLE;
        end else if (!press) begin
          tick_nxt = tick_inc;
        end else begin
          saved_nxt = tick;
          tick_nxt  = '0;
          phase_nxt = kced_pkg::PH_DEB2;
        end
      end
      kced_pkg::PH_DEB2: begin
        if (press && ge_deb) begin
          tick_nxt  = '0;
          phase_nxt = kced_pkg::PH_PRESS2;
        end else if (press) begin
          tick_nxt = tick_inc;
        end else begin
          // bounce: resume the wait, with the time spent in this debounce added
          tick_nxt  = tick_sum;
          phase_nxt = kced_pkg::PH_WAIT2;
        end
      end
      kced_pkg::PH_PRESS2: begin
        if (press && ge_long) begin
          tick_nxt   = '0;
          phase_nxt  = kced_pkg::PH_LONG;
          event_code = kced_pkg::EV_SINGLE;
        end else if (press) begin
          tick_nxt = tick_inc;
        end else begin
          tick_nxt   = '0;
          phase_nxt  = kced_pkg::PH_IDLE;
          event_code = kced_pkg::EV_DOUBLE;
        end
      end
      default: begin
        // idle and the unused code
        phase_nxt = press ? kced_pkg::PH_DEB : kced_pkg::PH_IDLE;
      end
    endcase
  end

endmodule

@@ sim/tb_key_click_event_detector_unit.sv @@
// Self-checking testbench for key_click_event_detector_unit: directed rows, then random
// press/release gestures with noise, checked beat by beat against a per-key click predictor.
// Depends on kced_pkg and the key_click_event_detector_unit RTL.
`timescale 1ns / 1ps

module tb_key_click_event_detector_unit;

  localparam int NUM_KEYS      = kced_pkg::NUM_KEYS_DEF;
  localparam int PIPE_LATENCY  = 2;      // input beat to result beat, with margin
  localparam int MAX_GAP       = 5;      // longest random idle per beat
  localparam int HOLD_AT       = 100;    // result count at which the receiver backs off
  localparam int HOLD_CYCLES   = 60;     // length of that back-off
  localparam int STUCK_LIMIT   = 2000;   // cycles without any beat before giving up
  localparam int RANDOM_PHASES = 6;
  localparam int RANDOM_ITEMS  = 500;
  localparam int MAX_REPORTS   = 10;

  typedef logic [kced_pkg::KEY_W-1:0]  key_t;
  typedef logic [kced_pkg::TICK_W-1:0] tick_t;
  typedef logic [kced_pkg::MODE_W-1:0] mode_t;

  localparam mode_t MODE_ALL  = '1;
  localparam mode_t MODE_NONE = '0;
  localparam tick_t TICKS_MAX = '1;

  typedef struct packed {
    logic [kced_pkg::KEY_W-1:0]  key;
    logic [kced_pkg::CODE_W-1:0] code;
  } click_result_t;

  // One row of the directed table: either a register write or an input beat,
  // optionally with a result code typed in by hand.
  typedef struct packed {
    logic                            is_cfg;
    logic                            typed;
    logic [kced_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [kced_pkg::CFG_DATA_W-1:0] reg_data;
    logic [kced_pkg::KEY_W-1:0]      key;
    logic                            pin;
    logic [kced_pkg::CODE_W-1:0]     code;
  } stim_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [kced_pkg::KEY_W-1:0]      in_key_index;
  logic                            in_pin_level;
  logic                            out_valid;
  logic                            out_stall;
  logic [kced_pkg::KEY_W-1:0]      out_event_key;
  logic [kced_pkg::CODE_W-1:0]     out_event_code;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [kced_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kced_pkg::CFG_DATA_W-1:0] cfg_data;

  // Predictor state: per-key phase, running tick count and the count saved
  // when a second press starts, plus a copy of the registers.
  logic [kced_pkg::PHASE_W-1:0] ph_mirror   [NUM_KEYS];
  logic [kced_pkg::TICK_W-1:0]  cnt_mirror  [NUM_KEYS];
  logic [kced_pkg::TICK_W-1:0]  save_mirror [NUM_KEYS];
  kced_pkg::cfg_t               cfg_mirror;

  click_result_t pending_events [$];
  stim_row_t     directed_rows [$];

  int mismatches   = 0;
  int results_seen = 0;
  int beats_sent   = 0;
  int stuck_cycles = 0;
  bit idle_off     = 1'b0;

  key_click_event_detector_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_key_index   (in_key_index),
    .in_pin_level   (in_pin_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_key  (out_event_key),
    .out_event_code (out_event_code),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Click predictor
  // ---------------------------------------------------------------------------

  // Add two counts, clamping at the counter's top value.
  function automatic tick_t sat_add(input tick_t a, input tick_t b);
    logic [kced_pkg::TICK_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[kced_pkg::TICK_W] ? TICKS_MAX : sum[kced_pkg::TICK_W-1:0];
  endfunction

  // Advance one key by one tick sample and return the event code it raises.
  function automatic logic [kced_pkg::CODE_W-1:0] click_event(input key_t k,
                                                              input logic pin);
    logic                         pressed;
    logic [kced_pkg::PHASE_W-1:0] ph;
    tick_t                        cnt;
    logic [kced_pkg::CODE_W-1:0]  code;
    pressed = (pin == cfg_mirror.pressed_level);
    ph      = ph_mirror[k];
    cnt     = cnt_mirror[k];
    code    = kced_pkg::EV_NONE;
    case (ph)
      kced_pkg::PH_DEB: begin
        if (pressed && cnt >= cfg_mirror.debounce_ticks) begin
          cnt = '0;
          ph  = kced_pkg::PH_PRESS;
        end else if (pressed) begin
          cnt = sat_add(cnt, tick_t'(1));
        end else begin
          cnt = '0;
          ph  = kced_pkg::PH_IDLE;
        end
      end
      kced_pkg::PH_PRESS: begin
        if (pressed && cnt >= cfg_mirror.long_press_ticks) begin
          cnt = cfg_mirror.repeat_ticks;
          ph  = kced_pkg::PH_LONG;
        end else if (pressed) begin
          cnt = sat_add(cnt, tick_t'(1));
        end else if (cfg_mirror.mode_bits[kced_pkg::MODE_DOUBLE_BIT]) begin
          cnt = '0;
          ph  = kced_pkg::PH_WAIT2;
        end else begin
          cnt  = '0;
          ph   = kced_pkg::PH_IDLE;
          code = kced_pkg::EV_SINGLE;
        end
      end
      kced_pkg::PH_LONG: begin
        if (pressed && cfg_mirror.mode_bits[kced_pkg::MODE_REPEAT_BIT]) begin
          if (cnt >= cfg_mirror.repeat_ticks) begin
            cnt  = '0;
            code = kced_pkg::EV_REPEAT;
          end else begin
            cnt = sat_add(cnt, tick_t'(1));
          end
        end else if (pressed) begin
          cnt = '0;
        end else begin
          cnt  = '0;
          ph   = kced_pkg::PH_IDLE;
          code = cfg_mirror.mode_bits[kced_pkg::MODE_LONG_BIT] ? kced_pkg::EV_LONG
                                                               : kced_pkg::EV_SINGLE;
        end
      end
      kced_pkg::PH_WAIT2: begin
        if (!pressed && cnt >= cfg_mirror.double_wait_ticks) begin
          cnt  = '0;
          ph   = kced_pkg::PH_IDLE;
          code = kced_pkg::EV_SINGLE;
        end else if (!pressed) begin
          cnt = sat_add(cnt, tick_t'(1));
        end else begin
          save_mirror[k] = cnt;
          cnt = '0;
          ph  = kced_pkg::PH_DEB2;
        end
      end
      kced_pkg::PH_DEB2: begin
        if (pressed && cnt >= cfg_mirror.debounce_ticks) begin
          cnt = '0;
          ph  = kced_pkg::PH_PRESS2;
        end else if (pressed) begin
          cnt = sat_add(cnt, tick_t'(1));
        end else begin
          // bounce: resume the wait with the time already spent added back
          cnt = sat_add(cnt, save_mirror[k]);
          ph  = kced_pkg::PH_WAIT2;
        end
      end
      kced_pkg::PH_PRESS2: begin
        if (pressed && cnt >= cfg_mirror.long_press_ticks) begin
          cnt  = '0;
          ph   = kced_pkg::PH_LONG;
          code = kced_pkg::EV_SINGLE;
        end else if (pressed) begin
          cnt = sat_add(cnt, tick_t'(1));
        end else begin
          cnt  = '0;
          ph   = kced_pkg::PH_IDLE;
          code = kced_pkg::EV_DOUBLE;
        end
      end
      default: ph = pressed ? kced_pkg::PH_DEB : kced_pkg::PH_IDLE;
    endcase
    ph_mirror[k]  = ph;
    cnt_mirror[k] = cnt;
    return code;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------

  function automatic stim_row_t beat_row(input key_t k, input logic p);
    stim_row_t r;
    r     = '0;
    r.key = k;
    r.pin = p;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input key_t k, input logic p,
                                          input logic [kced_pkg::CODE_W-1:0] c);
    stim_row_t r;
    r       = beat_row(k, p);
    r.typed = 1'b1;
    r.code  = c;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [kced_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [kced_pkg::CFG_DATA_W-1:0] val);
    stim_row_t r;
    r          = '0;
    r.is_cfg   = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = val;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one input beat after a random gap, hold it until accepted, then
  // queue its expected result (the predicted one, or a typed-in code).
  task automatic send_beat(input key_t k, input logic p,
                           input bit typed = 1'b0,
                           input logic [kced_pkg::CODE_W-1:0] fixed_code
                             = kced_pkg::EV_NONE);
    int            gap;
    click_result_t want;
    gap = idle_off ? 0 : $urandom_range(MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_key_index <= k;
    in_pin_level <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want.key  = k;
    want.code = click_event(k, p);
    if (typed)
      want.code = fixed_code;
    pending_events.push_back(want);
    beats_sent++;
  endtask

  // Drop valid and let every outstanding result come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // One register write; after the handshake it lowers cfg_valid before returning,
  // so that writes never lower and raise cfg_valid in the same step.
  task automatic write_reg(input logic [kced_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kced_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      kced_pkg::REG_DEBOUNCE:    cfg_mirror.debounce_ticks    = val;
      kced_pkg::REG_LONG_PRESS:  cfg_mirror.long_press_ticks  = val;
      kced_pkg::REG_REPEAT:      cfg_mirror.repeat_ticks      = val;
      kced_pkg::REG_DOUBLE_WAIT: cfg_mirror.double_wait_ticks = val;
      kced_pkg::REG_PRESSED_LVL: cfg_mirror.pressed_level     = val[0];
      kced_pkg::REG_MODE:        cfg_mirror.mode_bits = val[kced_pkg::MODE_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input tick_t deb, input tick_t lng,
                                input tick_t rep, input tick_t dw,
                                input logic lvl, input mode_t mode);
    wait_drained();
    write_reg(kced_pkg::REG_DEBOUNCE, deb);
    write_reg(kced_pkg::REG_LONG_PRESS, lng);
    write_reg(kced_pkg::REG_REPEAT, rep);
    write_reg(kced_pkg::REG_DOUBLE_WAIT, dw);
    write_reg(kced_pkg::REG_PRESSED_LVL, {{(kced_pkg::CFG_DATA_W-1){1'b0}}, lvl});
    write_reg(kced_pkg::REG_MODE,
              {{(kced_pkg::CFG_DATA_W-kced_pkg::MODE_W){1'b0}}, mode});
  endtask

  // Hold one key at a level for a number of ticks, with occasional bounces on
  // that key and noise beats on random keys mixed in.
  task automatic hold_key(input key_t k, input logic lvl, input int ticks);
    repeat (ticks) begin
      if ($urandom_range(3) == 0)
        send_beat(key_t'($urandom_range(NUM_KEYS - 1)), 1'($urandom_range(1)));
      if ($urandom_range(11) == 0)
        send_beat(k, !lvl);
      else
        send_beat(k, lvl);
    end
  endtask

  // A press, a release and, half the time, a second press and release, sized
  // around the current thresholds so that every phase gets visited.
  task automatic play_gesture();
    key_t k;
    logic down;
    int   span;
    int   rest;
    k    = key_t'($urandom_range(NUM_KEYS - 1));
    down = cfg_mirror.pressed_level;
    span = cfg_mirror.debounce_ticks + cfg_mirror.long_press_ticks
         + 2 * cfg_mirror.repeat_ticks + 4;
    rest = cfg_mirror.double_wait_ticks + 2;
    hold_key(k, down, $urandom_range(span, 1));
    hold_key(k, !down, $urandom_range(rest, 1));
    if ($urandom_range(1)) begin
      hold_key(k, down, $urandom_range(span, 1));
      hold_key(k, !down, $urandom_range(rest + 1, 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int    phase_end;
    int    top;
    mode_t mode;
    key_t  sat_key;

    // Drive every input to a known value from time zero.
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_key_index <= '0;
    in_pin_level <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= kced_pkg::REG_DEBOUNCE;
    cfg_data     <= '0;

    for (int i = 0; i < NUM_KEYS; i++) begin
      ph_mirror[i]   = kced_pkg::PH_IDLE;
      cnt_mirror[i]  = '0;
      save_mirror[i] = '0;
    end
    cfg_mirror.debounce_ticks    = kced_pkg::DEBOUNCE_RST;
    cfg_mirror.long_press_ticks  = kced_pkg::LONG_PRESS_RST;
    cfg_mirror.repeat_ticks      = kced_pkg::REPEAT_RST;
    cfg_mirror.double_wait_ticks = kced_pkg::DOUBLE_WAIT_RST;
    cfg_mirror.pressed_level     = kced_pkg::PRESSED_LVL_RST;
    cfg_mirror.mode_bits         = kced_pkg::MODE_RST;

    // Directed table. After reset a low pin means pressed.
    directed_rows.push_back(typed_row(3'd0, 1'b1, kced_pkg::EV_NONE)); // released, idle
    directed_rows.push_back(typed_row(3'd7, 1'b0, kced_pkg::EV_NONE)); // starts debounce
    // Zero every threshold and flip the pressed level, so each tick advances.
    directed_rows.push_back(reg_row(kced_pkg::REG_DEBOUNCE, 16'd0));
    directed_rows.push_back(reg_row(kced_pkg::REG_LONG_PRESS, 16'd0));
    directed_rows.push_back(reg_row(kced_pkg::REG_REPEAT, 16'd0));
    directed_rows.push_back(reg_row(kced_pkg::REG_DOUBLE_WAIT, 16'd0));
    directed_rows.push_back(reg_row(kced_pkg::REG_PRESSED_LVL, 16'd1));
    directed_rows.push_back(reg_row(kced_pkg::REG_MODE,
      {{(kced_pkg::CFG_DATA_W-kced_pkg::MODE_W){1'b0}}, MODE_ALL}));
    // Long press with a quick repeat, then release into a long event.
    directed_rows.push_back(typed_row(3'd3, 1'b1, kced_pkg::EV_NONE));
    directed_rows.push_back(beat_row(3'd3, 1'b1));
    directed_rows.push_back(beat_row(3'd3, 1'b1));
    directed_rows.push_back(typed_row(3'd3, 1'b1, kced_pkg::EV_REPEAT));
    directed_rows.push_back(typed_row(3'd3, 1'b0, kced_pkg::EV_LONG));
    // Double click.
    directed_rows.push_back(beat_row(3'd5, 1'b1));
    directed_rows.push_back(beat_row(3'd5, 1'b1));
    directed_rows.push_back(beat_row(3'd5, 1'b0));
    directed_rows.push_back(beat_row(3'd5, 1'b1));
    directed_rows.push_back(beat_row(3'd5, 1'b1));
    directed_rows.push_back(typed_row(3'd5, 1'b0, kced_pkg::EV_DOUBLE));
    // Second press never comes: single click once the wait expires.
    directed_rows.push_back(beat_row(3'd6, 1'b1));
    directed_rows.push_back(beat_row(3'd6, 1'b1));
    directed_rows.push_back(beat_row(3'd6, 1'b0));
    directed_rows.push_back(typed_row(3'd6, 1'b0, kced_pkg::EV_SINGLE));
    // Bounce during the second debounce, back to waiting.
    directed_rows.push_back(beat_row(3'd4, 1'b1));
    directed_rows.push_back(beat_row(3'd4, 1'b1));
    directed_rows.push_back(beat_row(3'd4, 1'b0));
    directed_rows.push_back(beat_row(3'd4, 1'b1));
    directed_rows.push_back(beat_row(3'd4, 1'b0));
    directed_rows.push_back(beat_row(3'd4, 1'b0));
    // All modes off: a long hold releases as a plain single click.
    directed_rows.push_back(reg_row(kced_pkg::REG_MODE,
      {{(kced_pkg::CFG_DATA_W-kced_pkg::MODE_W){1'b0}}, MODE_NONE}));
    directed_rows.push_back(beat_row(3'd2, 1'b1));
    directed_rows.push_back(beat_row(3'd2, 1'b1));
    directed_rows.push_back(beat_row(3'd2, 1'b1));
    directed_rows.push_back(typed_row(3'd2, 1'b0, kced_pkg::EV_SINGLE));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_drained();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_beat(directed_rows[i].key, directed_rows[i].pin,
                  directed_rows[i].typed, directed_rows[i].code);
      end
    end

    // Random gestures under several small settings. Alternate the pressed
    // level, force all-on and all-off modes once, and run one phase with no
    // idling on either side.
    for (int ph_i = 0; ph_i < RANDOM_PHASES; ph_i++) begin
      top  = (ph_i == 3) ? 15 : 6;
      mode = mode_t'($urandom_range(7));
      if (ph_i == 0)
        mode = MODE_ALL;
      else if (ph_i == 1)
        mode = MODE_NONE;
      apply_settings(tick_t'($urandom_range(top)), tick_t'($urandom_range(top)),
                     tick_t'($urandom_range(top)), tick_t'($urandom_range(top)),
                     ph_i[0], mode);
      idle_off  = (ph_i == 2);
      phase_end = beats_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (beats_sent < phase_end)
        play_gesture();
    end

    // Counter limits: with the repeat interval at the top, the long-press
    // reload lands on the counter's top value and the next held tick repeats
    // at once; then count up from zero and release.
    idle_off = 1'b1;
    sat_key  = key_t'($urandom_range(NUM_KEYS - 1));
    apply_settings(16'd0, 16'd0, TICKS_MAX, 16'd0, 1'b1, MODE_ALL);
    while (ph_mirror[sat_key] != kced_pkg::PH_IDLE)
      send_beat(sat_key, 1'b0);
    repeat (5) send_beat(sat_key, 1'b1);
    send_beat(sat_key, 1'b0);

    wait_drained();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && pending_events.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------
  // Stall a random number of cycles before each result beat; once, hold off
  // long enough for the pipeline to back up into in_stall.
  initial begin
    int            pause;
    click_result_t want;
    out_stall <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (results_seen == HOLD_AT)
        pause = HOLD_CYCLES;
      else
        pause = idle_off ? 0 : $urandom_range(MAX_GAP);
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d with nothing pending: key %0d code %0d",
                   results_seen, out_event_key, out_event_code);
      end else begin
        want = pending_events.pop_front();
        if (out_event_key !== want.key || out_event_code !== want.code) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d mismatch: expected key %0d code %0d, got key %0d code %0d",
                     results_seen, want.key, want.code, out_event_key, out_event_code);
        end
      end
      results_seen++;
    end
  end

  // Watchdog: give up when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
